// ===== rtl/midi_track_event_parser_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define MTEP_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtep check failed");

// Next-cycle implication, ignored while reset is high.
`define MTEP_IMPLY_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtep check failed");

// Next-cycle implication that also holds across reset.
`define MTEP_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mtep check failed");

`endif

// ===== rtl/mtep_pkg.sv =====
package mtep_pkg;

  localparam int FIELD_BITS = 28;
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = 28'hFFF_FFFF;

  // Result kinds
  localparam logic [3:0] KIND_META    = 4'd7;
  localparam logic [3:0] KIND_SYSEX   = 4'd8;
  localparam logic [3:0] KIND_PAYLOAD = 4'd9;

  // Status codes
  localparam logic [7:0] ST_CHAN_FIRST = 8'h80;
  localparam logic [7:0] ST_CHAN_LAST  = 8'hEF;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] META_END      = 8'h2F;

  // Status high nibbles
  localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
  localparam logic [3:0] NIB_PROGRAM    = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
  localparam logic [3:0] NIB_PITCH      = 4'hE;

  localparam logic [2:0] HEADER_LAST = 3'd7;

  typedef struct packed {
    logic [3:0]            kind;
    logic [FIELD_BITS-1:0] delta_ticks;
    logic [3:0]            channel_num;
    logic [7:0]            first_byte;
    logic [7:0]            second_byte;
    logic [14:0]           wheel_value;
    logic [7:0]            meta_type;
    logic [FIELD_BITS-1:0] payload_length;
    logic                  last_of_event;
    logic                  track_end;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t evt;
  } result_t;

endpackage

// ===== rtl/mtep_byte_if.sv =====
interface mtep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== rtl/mtep_event_if.sv =====
interface mtep_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [27:0] delta_ticks;
  logic [3:0]  channel_num;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic [14:0] wheel_value;
  logic [7:0]  meta_type;
  logic [27:0] payload_length;
  logic        last_of_event;
  logic        track_end;

  modport source (
    output valid, output kind, output delta_ticks, output channel_num,
    output first_byte, output second_byte, output wheel_value, output meta_type,
    output payload_length, output last_of_event, output track_end,
    input ready
  );
  modport sink (
    input valid, input kind, input delta_ticks, input channel_num,
    input first_byte, input second_byte, input wheel_value, input meta_type,
    input payload_length, input last_of_event, input track_end,
    output ready
  );
endinterface

// ===== rtl/midi_track_event_parser_core.sv =====
// MIDI track event parser.
// Track input: one raw byte of a track chunk per beat, header bytes included.
// The first 8 bytes of each track (chunk id and size) are skipped.
// Events output: at most one decoded event per input beat. Channel messages
// come out complete with their data bytes; meta and sysex events come out as a
// descriptor with the payload length, then one payload beat per byte, with
// last_of_event on the final beat and track_end on the end-of-track meta.
// Timing: an event is written into the output queue when the byte that
// completes it is accepted. Throughput: one byte per cycle while the queue has
// a free entry; a new byte is taken in every cycle that track.ready is high.
// Stall: a two-entry output queue holds results; track.ready drops only when
// both entries hold events that events has not taken yet, or while rst is high.
// Reset (rst, synchronous): the queue empties, running status clears, and the
// parser expects the header bytes of a new track.
module midi_track_event_parser_core #(
  parameter int VALUE_BITS = 28
) (
  input logic        clk,
  input logic        rst,
  mtep_byte_if.sink  track,
  mtep_event_if.source events
);
  import mtep_pkg::*;

  result_t parse_res;
  event_t  head_evt;
  logic    queue_full;
  logic    take;

  // Accept a byte whenever the queue has a free entry and reset is low
  assign track.ready = !queue_full && !rst;
  assign take        = track.valid && track.ready;

  mtep_parser #(
    .VALUE_BITS(VALUE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .stream_byte(track.stream_byte),
    .res        (parse_res)
  );

  // Hold finished events until the receiver takes them
  mtep_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (parse_res),
    .pop_ready(events.ready),
    .out_valid(events.valid),
    .out_evt  (head_evt),
    .full     (queue_full)
  );

  assign events.kind           = head_evt.kind;
  assign events.delta_ticks    = head_evt.delta_ticks;
  assign events.channel_num    = head_evt.channel_num;
  assign events.first_byte     = head_evt.first_byte;
  assign events.second_byte    = head_evt.second_byte;
  assign events.wheel_value    = head_evt.wheel_value;
  assign events.meta_type      = head_evt.meta_type;
  assign events.payload_length = head_evt.payload_length;
  assign events.last_of_event  = head_evt.last_of_event;
  assign events.track_end      = head_evt.track_end;

endmodule

// ===== rtl/mtep_parser.sv =====
module mtep_parser #(
  parameter int VALUE_BITS = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        stream_byte,
  output mtep_pkg::result_t res
);
  import mtep_pkg::*;

  localparam int EXT_BITS = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

  typedef enum logic [3:0] {
    PH_HEADER, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
    PH_MTYPE, PH_MLEN, PH_SLEN, PH_PAYLOAD
  } phase_t;

  phase_t                phase, phase_next;
  logic [2:0]            header_count, header_count_next;
  logic [VALUE_BITS-1:0] value_acc, value_acc_next;
  logic [VALUE_BITS-1:0] held_delta, held_delta_next;
  logic [7:0]            running_status, running_status_next;
  logic [7:0]            first_data, first_data_next;
  logic [7:0]            held_meta_type, held_meta_type_next;
  logic [VALUE_BITS-1:0] remaining_count, remaining_count_next;
  logic                  end_pending, end_pending_next;

  // Saturating variable-length step
  logic [VALUE_BITS+6:0] vlq_wide;
  logic [VALUE_BITS-1:0] vlq_value;
  logic                  vlq_done;

  function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [VALUE_BITS-1:0] x);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(x);
    if (e > EXT_BITS'(FIELD_MAX)) return FIELD_MAX;
    return e[FIELD_BITS-1:0];
  endfunction

  function automatic logic has_two_data(input logic [7:0] st);
    return (st[7:4] != NIB_PROGRAM) && (st[7:4] != NIB_CHAN_PRESS);
  endfunction

  function automatic event_t channel_event(input logic [7:0] st, input logic [7:0] b1,
                                           input logic [7:0] b2,
                                           input logic [FIELD_BITS-1:0] delta);
    event_t e;
    e = '0;
    e.kind          = st[7:4] - NIB_NOTE_OFF;
    e.delta_ticks   = delta;
    e.channel_num   = st[3:0];
    e.first_byte    = b1;
    e.second_byte   = has_two_data(st) ? b2 : 8'h00;
    e.wheel_value   = (st[7:4] == NIB_PITCH) ? ({b2, 7'b0} | {7'b0, b1}) : 15'd0;
    e.last_of_event = 1'b1;
    return e;
  endfunction

  assign vlq_wide  = {value_acc, stream_byte[6:0]};
  assign vlq_value = (|vlq_wide[VALUE_BITS+6:VALUE_BITS]) ? '1 : vlq_wide[VALUE_BITS-1:0];
  assign vlq_done  = !stream_byte[7];

  always_comb begin
    logic                  running;
    logic [7:0]            st;
    logic [VALUE_BITS-1:0] len;
    logic                  len_ready;
    logic                  len_meta;
    logic                  finish;
    logic [VALUE_BITS-1:0] rem_dec;
    logic [FIELD_BITS-1:0] delta_out;

    phase_next           = phase;
    header_count_next    = header_count;
    value_acc_next       = value_acc;
    held_delta_next      = held_delta;
    running_status_next  = running_status;
    first_data_next      = first_data;
    held_meta_type_next  = held_meta_type;
    remaining_count_next = remaining_count;
    end_pending_next     = end_pending;
    res                  = '0;

    running   = !stream_byte[7];
    st        = running ? running_status : stream_byte;
    len       = vlq_value;
    len_ready = 1'b0;
    len_meta  = 1'b0;
    finish    = 1'b0;
    rem_dec   = (remaining_count != '0) ? remaining_count - VALUE_BITS'(1) : '0;
    delta_out = clamp_field(held_delta);

    case (phase)
      PH_HEADER: begin
        if (header_count >= HEADER_LAST) begin
          header_count_next = '0;
          value_acc_next    = '0;
          phase_next        = PH_DELTA;
        end else begin
          header_count_next = header_count + 3'd1;
        end
      end
      PH_DELTA: begin
        value_acc_next = vlq_done ? '0 : vlq_value;
        if (vlq_done) begin
          held_delta_next = vlq_value;
          phase_next      = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!running) running_status_next = stream_byte;
        if (st == ST_META) begin
          if (running) begin
            held_meta_type_next = stream_byte;
            end_pending_next    = (stream_byte == META_END);
            value_acc_next      = '0;
            phase_next          = PH_MLEN;
          end else begin
            phase_next = PH_MTYPE;
          end
        end else if (st == ST_SYSEX || st == ST_SYSEX_ESC) begin
          // A data byte here is already a complete one-byte length
          value_acc_next = '0;
          phase_next     = PH_SLEN;
          if (running) begin
            len       = VALUE_BITS'(stream_byte[6:0]);
            len_ready = 1'b1;
          end
        end else if (st >= ST_CHAN_FIRST && st <= ST_CHAN_LAST) begin
          if (!running) begin
            phase_next = PH_DATA1;
          end else if (has_two_data(st)) begin
            first_data_next = stream_byte;
            phase_next      = PH_DATA2;
          end else begin
            res.valid  = 1'b1;
            res.evt    = channel_event(st, stream_byte, 8'h00, delta_out);
            phase_next = PH_DELTA;
          end
        end else if (running) begin
          // No usable running status: take the byte as a delta time
          held_delta_next = VALUE_BITS'(stream_byte);
          value_acc_next  = '0;
          phase_next      = PH_STATUS;
        end else begin
          value_acc_next = '0;
          phase_next     = PH_DELTA;
        end
      end
      PH_DATA1: begin
        if (has_two_data(running_status)) begin
          first_data_next = stream_byte;
          phase_next      = PH_DATA2;
        end else begin
          res.valid  = 1'b1;
          res.evt    = channel_event(running_status, stream_byte, 8'h00, delta_out);
          phase_next = PH_DELTA;
        end
      end
      PH_DATA2: begin
        res.valid  = 1'b1;
        res.evt    = channel_event(running_status, first_data, stream_byte, delta_out);
        phase_next = PH_DELTA;
      end
      PH_MTYPE: begin
        held_meta_type_next = stream_byte;
        end_pending_next    = (stream_byte == META_END);
        value_acc_next      = '0;
        phase_next          = PH_MLEN;
      end
      PH_MLEN, PH_SLEN: begin
        value_acc_next = vlq_done ? '0 : vlq_value;
        len_ready      = vlq_done;
        len_meta       = (phase == PH_MLEN);
      end
      PH_PAYLOAD: begin
        remaining_count_next  = rem_dec;
        res.valid             = 1'b1;
        res.evt.kind          = KIND_PAYLOAD;
        res.evt.delta_ticks   = delta_out;
        res.evt.first_byte    = stream_byte;
        res.evt.last_of_event = (rem_dec == '0);
        res.evt.track_end     = (rem_dec == '0) && end_pending;
        finish                = (rem_dec == '0);
      end
      default: begin
        phase_next           = PH_HEADER;
        header_count_next    = '0;
        value_acc_next       = '0;
        held_delta_next      = '0;
        running_status_next  = '0;
        first_data_next      = '0;
        held_meta_type_next  = '0;
        remaining_count_next = '0;
        end_pending_next     = 1'b0;
      end
    endcase

    // Length complete: emit the descriptor, then payload or finish
    if (len_ready) begin
      remaining_count_next   = len;
      res.valid              = 1'b1;
      res.evt                = '0;
      res.evt.kind           = len_meta ? KIND_META : KIND_SYSEX;
      res.evt.delta_ticks    = delta_out;
      res.evt.meta_type      = len_meta ? held_meta_type : 8'h00;
      res.evt.payload_length = clamp_field(len);
      res.evt.last_of_event  = (len == '0);
      res.evt.track_end      = (len == '0) && end_pending;
      if (len == '0) finish = 1'b1;
      else phase_next = PH_PAYLOAD;
    end

    if (finish) begin
      if (end_pending) begin
        end_pending_next    = 1'b0;
        running_status_next = '0;
        header_count_next   = '0;
        phase_next          = PH_HEADER;
      end else begin
        phase_next = PH_DELTA;
      end
    end

    if (!take) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      value_acc       <= '0;
      held_delta      <= '0;
      running_status  <= '0;
      first_data      <= '0;
      held_meta_type  <= '0;
      remaining_count <= '0;
      end_pending     <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      value_acc       <= value_acc_next;
      held_delta      <= held_delta_next;
      running_status  <= running_status_next;
      first_data      <= first_data_next;
      held_meta_type  <= held_meta_type_next;
      remaining_count <= remaining_count_next;
      end_pending     <= end_pending_next;
    end
  end

endmodule

// ===== rtl/mtep_out_buf.sv =====
module mtep_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  mtep_pkg::result_t push,
  input  logic              pop_ready,
  output logic              out_valid,
  output mtep_pkg::event_t  out_evt,
  output logic              full
);
  import mtep_pkg::*;

  event_t     head;
  event_t     slot1;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign out_evt   = head;
  assign full      = (count == 2'd2);
  assign pop       = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) head <= slot1;
      else if (push.valid) head <= push.evt;
    end else if (push.valid && count == 2'd0) begin
      head <= push.evt;
    end
    if (push.valid && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      slot1 <= push.evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/mtep_checker.sv =====
`include "midi_track_event_parser_core_assert.svh"

module mtep_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  kind,
  input logic [7:0]  first_byte,
  input logic [27:0] payload_length,
  input logic        last_of_event,
  input logic        track_end
);
  import mtep_pkg::*;

  `MTEP_ALWAYS_NEXT(a_reset_empties, clk, rst, !out_valid)
  `MTEP_IMPLY_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(kind) && $stable(first_byte))
  `MTEP_IMPLY(a_full_shows_event, clk, rst, !in_ready, out_valid)
  `MTEP_IMPLY(a_end_is_last, clk, rst, out_valid && track_end, last_of_event)
  `MTEP_IMPLY(a_length_only_desc, clk, rst, out_valid && kind != KIND_META && kind != KIND_SYSEX, payload_length == 28'd0)

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (track.ready),
  .out_valid     (events.valid),
  .out_ready     (events.ready),
  .kind          (events.kind),
  .first_byte    (events.first_byte),
  .payload_length(events.payload_length),
  .last_of_event (events.last_of_event),
  .track_end     (events.track_end)
);
